/* src/las_pkg.sv */
package las_pkg;

    // Animation phases, as reported on the phase output.
    typedef enum logic [2:0] {
        PH_LEFT  = 3'd0,
        PH_RIGHT = 3'd1,
        PH_IN    = 3'd2,
        PH_OUT   = 3'd3,
        PH_BLINK = 3'd4
    } las_mode_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEP_TICKS   = 2'd0;
    localparam logic [1:0] REG_BLINK_TICKS  = 2'd1;
    localparam logic [1:0] REG_SWEEP_ROUNDS = 2'd2;
    localparam logic [1:0] REG_BLINK_LIMIT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] STEP_TICKS_RST   = 8'd2;
    localparam logic [7:0] BLINK_TICKS_RST  = 8'd5;
    localparam logic [7:0] SWEEP_ROUNDS_RST = 8'd4;
    localparam logic [7:0] BLINK_LIMIT_RST  = 8'd8;

    // Walking bit end points and pair index start points.
    localparam logic [7:0] WALK_LOW   = 8'h01;
    localparam logic [7:0] WALK_HIGH  = 8'h80;
    localparam logic [3:0] IN_UPPER   = 4'd4;
    localparam logic [3:0] IN_LOWER   = 4'd3;
    localparam logic [3:0] OUT_UPPER  = 4'd7;
    localparam logic [3:0] OUT_LOWER  = 4'd0;
    localparam logic [3:0] PAIR_SUM   = 4'd7;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0] step_ticks;
        logic [7:0] blink_ticks;
        logic [7:0] sweep_rounds;
        logic [7:0] blink_limit;
    } las_cfg_t;

    // Animation state.
    typedef struct packed {
        las_mode_t  mode;
        logic [7:0] tick_count;
        logic [7:0] walking;
        logic [7:0] round_count;
        logic [3:0] upper;
        logic [3:0] lower;
        logic [7:0] pattern;
    } las_state_t;

    // One-hot mask of an LED index; an index beyond 7 selects no LED.
    function automatic logic [7:0] pin_mask(input logic [3:0] idx);
        logic [7:0] m;
        m = 8'h00;
        if (!idx[3]) begin
            m[idx[2:0]] = 1'b1;
        end
        return m;
    endfunction

endpackage

/* src/las_cfg.sv */
module las_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output las_pkg::las_cfg_t   cfg
);
    import las_pkg::*;

    las_cfg_t cfg_reg;

    // Register file written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks   <= STEP_TICKS_RST;
            cfg_reg.blink_ticks  <= BLINK_TICKS_RST;
            cfg_reg.sweep_rounds <= SWEEP_ROUNDS_RST;
            cfg_reg.blink_limit  <= BLINK_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_TICKS:   cfg_reg.step_ticks   <= cfg_data;
                REG_BLINK_TICKS:  cfg_reg.blink_ticks  <= cfg_data;
                REG_SWEEP_ROUNDS: cfg_reg.sweep_rounds <= cfg_data;
                REG_BLINK_LIMIT:  cfg_reg.blink_limit  <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/las_step.sv */
module las_step (
    input  las_pkg::las_state_t state,
    input  las_pkg::las_cfg_t   cfg,
    input  logic                tick,
    output las_pkg::las_state_t state_next,
    output logic                written
);
    import las_pkg::*;

    logic [8:0] cnt;
    logic [7:0] limit;
    logic       act;
    logic [7:0] walk_up;
    logic [7:0] walk_down;
    logic [7:0] round_inc;
    logic       round_end;
    logic [3:0] up_inc;
    logic [3:0] up_dec;
    logic [8:0] toggles;
    logic [7:0] pair;

    // Interval counter and shared helper values.
    always_comb
    begin
        cnt       = {1'b0, state.tick_count} + 9'd1;
        limit     = (state.mode == PH_BLINK) ? cfg.blink_ticks : cfg.step_ticks;
        act       = (cnt >= {1'b0, limit});
        walk_up   = state.walking << 1;
        walk_down = state.walking >> 1;
        round_inc = state.round_count + 8'd1;
        round_end = (round_inc >= cfg.sweep_rounds);
        up_inc    = state.upper + 4'd1;
        up_dec    = state.upper - 4'd1;
        toggles   = {1'b0, state.round_count} + 9'd1;
        pair      = pin_mask(state.upper) | pin_mask(state.lower);
    end

    // One animation step per tick that reaches its interval.
    always_comb
    begin
        state_next = state;
        written    = 1'b0;
        if (tick)
        begin
            state_next.tick_count = act ? 8'd0 : cnt[7:0];
            if (act)
            begin
                written = 1'b1;
                case (state.mode)
                    PH_LEFT:
                    begin
                        state_next.pattern = state.walking;
                        state_next.walking = walk_up;
                        if (walk_up == 8'h00)
                        begin
                            state_next.mode    = PH_RIGHT;
                            state_next.walking = WALK_HIGH;
                        end
                    end
                    PH_RIGHT:
                    begin
                        state_next.pattern = state.walking;
                        state_next.walking = walk_down;
                        if (walk_down == 8'h00)
                        begin
                            state_next.walking = WALK_LOW;
                            if (round_end)
                            begin
                                state_next.mode        = PH_IN;
                                state_next.round_count = 8'd0;
                            end
                            else
                            begin
                                state_next.mode        = PH_LEFT;
                                state_next.round_count = round_inc;
                            end
                        end
                    end
                    PH_IN:
                    begin
                        state_next.pattern = state.pattern | pair;
                        state_next.upper   = up_inc;
                        state_next.lower   = state.lower - 4'd1;
                        if (up_inc > 4'd7)
                        begin
                            state_next.mode  = PH_OUT;
                            state_next.upper = OUT_UPPER;
                            state_next.lower = OUT_LOWER;
                        end
                    end
                    PH_OUT:
                    begin
                        state_next.pattern = state.pattern & ~pair;
                        state_next.upper   = up_dec;
                        state_next.lower   = state.lower + 4'd1;
                        if (up_dec < 4'd4)
                        begin
                            state_next.upper = IN_UPPER;
                            state_next.lower = IN_LOWER;
                            if (round_end)
                            begin
                                state_next.mode        = PH_BLINK;
                                state_next.round_count = 8'd0;
                            end
                            else
                            begin
                                state_next.mode        = PH_IN;
                                state_next.round_count = round_inc;
                            end
                        end
                    end
                    PH_BLINK:
                    begin
                        if (toggles > {1'b0, cfg.blink_limit})
                        begin
                            state_next.mode        = PH_LEFT;
                            state_next.round_count = 8'd0;
                            state_next.pattern     = 8'h00;
                        end
                        else
                        begin
                            state_next.pattern     = ~state.pattern;
                            state_next.round_count = toggles[7:0];
                        end
                    end
                    default:
                    begin
                        written = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

/* src/led_animation_sequencer.sv */
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   tick
// output    out        out_valid/out_stall led_pattern, phase, pattern_written
// config    in         cfg_write           cfg_index, cfg_data
//
// Each item waits in the input register, then one step of the animation
// logic loads the result register; one item is taken per clock unless
// in_stall is high. The animation state advances as the item moves
// into the result register. Reset puts the animation in the shift left phase
// with all LEDs off. A stalled output holds its result, and the input stalls
// only while both the input register and the result register are full.
module led_animation_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       tick,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] led_pattern,
    output logic [2:0] phase,
    output logic       pattern_written,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import las_pkg::*;

    las_cfg_t   cfg;
    las_state_t state_reg;
    las_state_t state_next;
    logic       written_next;
    logic       in_valid_reg;
    logic       tick_reg;
    logic       out_valid_reg;
    logic [7:0] led_pattern_reg;
    logic [2:0] phase_reg;
    logic       written_reg;
    logic       advance;

    las_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    las_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .tick       (tick_reg),
        .state_next (state_next),
        .written    (written_next)
    );

    // The held item moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            tick_reg <= tick;
        end
    end

    // Animation state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= PH_LEFT;
            state_reg.tick_count  <= 8'd0;
            state_reg.walking     <= WALK_LOW;
            state_reg.round_count <= 8'd0;
            state_reg.upper       <= IN_UPPER;
            state_reg.lower       <= IN_LOWER;
            state_reg.pattern     <= 8'h00;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_pattern_reg <= state_next.pattern;
            phase_reg       <= state_next.mode;
            written_reg     <= written_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_pattern     = led_pattern_reg;
    assign phase           = phase_reg;
    assign pattern_written = written_reg;

    // The walking bit always holds exactly one lit position.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.walking))
        else $error("walking bit lost its single set bit");

    // Fill and clear indexes always form a mirrored pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.upper + state_reg.lower) == PAIR_SUM)
        else $error("pair indexes out of step");

    // The animation state moves only when an item reaches the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // An item that advances always produces a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced item produced no result");

endmodule

/* sim/led_animation_sequencer_test.sv */
module led_animation_sequencer_test;

    import las_pkg::*;

    // One result item of the block.
    typedef struct packed {
        logic [7:0] led;
        logic [2:0] phase;
        logic       written;
    } frame_t;

    // Tracks the animation state, predicts each frame and checks what arrives.
    class animation_scoreboard;
        las_cfg_t   cfg;
        las_mode_t  mode;
        logic [7:0] tick_count;
        logic [7:0] walking;
        logic [7:0] round_count;
        logic [3:0] upper;
        logic [3:0] lower;
        logic [7:0] pattern;
        frame_t     pending_frames[$];
        int         fails;

        function new();
            cfg.step_ticks   = STEP_TICKS_RST;
            cfg.blink_ticks  = BLINK_TICKS_RST;
            cfg.sweep_rounds = SWEEP_ROUNDS_RST;
            cfg.blink_limit  = BLINK_LIMIT_RST;
            mode        = PH_LEFT;
            tick_count  = 8'd0;
            walking     = WALK_LOW;
            round_count = 8'd0;
            upper       = IN_UPPER;
            lower       = IN_LOWER;
            pattern     = 8'h00;
            fails       = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        function void write_reg(input logic [1:0] idx, input logic [7:0] val);
            case (idx)
                REG_STEP_TICKS:   cfg.step_ticks   = val;
                REG_BLINK_TICKS:  cfg.blink_ticks  = val;
                REG_SWEEP_ROUNDS: cfg.sweep_rounds = val;
                REG_BLINK_LIMIT:  cfg.blink_limit  = val;
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pending_frames.size();
        endfunction

        // LED select for a pair index; indexes past the top LED light nothing.
        function logic [7:0] lamp_bit(input logic [3:0] idx);
            return (idx < 4'd8) ? (8'h01 << idx) : 8'h00;
        endfunction

        // Counts a finished round and tells whether the round budget is used up.
        function bit close_round();
            round_count = round_count + 8'd1;
            if (round_count >= cfg.sweep_rounds) begin
                round_count = 8'd0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advances the animation by one item and returns the frame it shows.
        function frame_t advance_animation(input logic tick_in);
            frame_t     f;
            logic [8:0] cnt;
            logic [8:0] toggles;
            logic [7:0] interval;
            bit         act;
            f.written = 1'b0;
            if (tick_in) begin
                cnt = {1'b0, tick_count} + 9'd1;
                interval = (mode == PH_BLINK) ? cfg.blink_ticks : cfg.step_ticks;
                act = (cnt >= {1'b0, interval});
                tick_count = act ? 8'd0 : cnt[7:0];
                if (act) begin
                    f.written = 1'b1;
                    case (mode)
                        PH_LEFT:
                        begin
                            pattern = walking;
                            walking = walking << 1;
                            if (walking == 8'h00) begin
                                mode = PH_RIGHT;
                                walking = WALK_HIGH;
                            end
                        end
                        PH_RIGHT:
                        begin
                            pattern = walking;
                            walking = walking >> 1;
                            if (walking == 8'h00) begin
                                mode = PH_LEFT;
                                walking = WALK_LOW;
                                if (close_round())
                                    mode = PH_IN;
                            end
                        end
                        PH_IN:
                        begin
                            pattern = pattern | lamp_bit(upper) | lamp_bit(lower);
                            upper = upper + 4'd1;
                            lower = lower - 4'd1;
                            if (upper > 4'd7) begin
                                mode = PH_OUT;
                                upper = OUT_UPPER;
                                lower = OUT_LOWER;
                            end
                        end
                        PH_OUT:
                        begin
                            pattern = pattern & ~(lamp_bit(upper) | lamp_bit(lower));
                            upper = upper - 4'd1;
                            lower = lower + 4'd1;
                            if (upper < 4'd4) begin
                                mode = PH_IN;
                                upper = IN_UPPER;
                                lower = IN_LOWER;
                                if (close_round())
                                    mode = PH_BLINK;
                            end
                        end
                        PH_BLINK:
                        begin
                            // The toggle count carries a ninth bit so a limit of 255 ends.
                            toggles = {1'b0, round_count} + 9'd1;
                            pattern = pattern ^ 8'hFF;
                            if (toggles > {1'b0, cfg.blink_limit}) begin
                                mode = PH_LEFT;
                                round_count = 8'd0;
                                pattern = 8'h00;
                            end
                            else begin
                                round_count = toggles[7:0];
                            end
                        end
                        default: f.written = 1'b0;
                    endcase
                end
            end
            f.led = pattern;
            f.phase = mode;
            return f;
        endfunction

        function void note_tick(input logic tick_in);
            pending_frames.push_back(advance_animation(tick_in));
        endfunction

        task check_frame(input logic [7:0] led, input logic [2:0] ph, input logic wr);
            frame_t exp_f;
            if (pending_frames.size() == 0) begin
                report($sformatf("frame led=%h phase=%0d with nothing expected", led, ph));
            end
            else begin
                exp_f = pending_frames.pop_front();
                if (led !== exp_f.led)
                    report($sformatf("led_pattern %h, expected %h", led, exp_f.led));
                if (ph !== exp_f.phase)
                    report($sformatf("phase %0d, expected %0d", ph, exp_f.phase));
                if (wr !== exp_f.written)
                    report($sformatf("pattern_written %b, expected %b", wr, exp_f.written));
            end
        endtask

        task flag_leftovers();
            if (pending_frames.size() != 0)
                report($sformatf("%0d frames never arrived", pending_frames.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       tick;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] led_pattern;
    logic [2:0] phase;
    logic       pattern_written;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    animation_scoreboard sb = new();
    bit calm = 1'b0;
    int cycle_count = 0;
    localparam int CYCLE_LIMIT = 100000;

    led_animation_sequencer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .tick            (tick),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .led_pattern     (led_pattern),
        .phase           (phase),
        .pattern_written (pattern_written),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watch both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_tick(tick);
            if (out_valid && !out_stall)
                sb.check_frame(led_pattern, phase, pattern_written);
        end
    end

    // The receiver stalls now and then, except in reset and the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < 8);
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("led_animation_sequencer regression: fail");
            $finish;
        end
    end

    // Offers one item and holds it until the block takes it.
    task send_item(input logic t);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sends random ticks; about one in ten is a low tick.
    task send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item($urandom_range(9) != 0);
    endtask

    // Lets every expected frame arrive and the pipeline settle.
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task set_config(input logic [7:0] step, input logic [7:0] blink,
                    input logic [7:0] rounds, input logic [7:0] limit);
        write_reg(REG_STEP_TICKS, step);
        write_reg(REG_BLINK_TICKS, blink);
        write_reg(REG_SWEEP_ROUNDS, rounds);
        write_reg(REG_BLINK_LIMIT, limit);
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        tick = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_STEP_TICKS;
        cfg_data = 8'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: low ticks hold the frame, high ticks walk the bit.
        send_item(1'b0);
        send_item(1'b0);
        for (int i = 0; i < 20; i++)
            send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();

        // Fastest settings: every phase in a few ticks, blink ends without a toggle.
        set_config(8'd1, 8'd1, 8'd1, 8'd0);
        send_ticks(120);
        drain();

        // Zero intervals and rounds, full-length blink, no idling on either side.
        calm = 1'b1;
        set_config(8'd0, 8'd0, 8'd0, 8'd255);
        send_ticks(300);
        drain();
        calm = 1'b0;

        // Largest settings: the tick counter climbs without a step.
        set_config(8'd255, 8'd255, 8'd255, 8'd254);
        send_ticks(40);
        drain();

        // Intervals dropped below the running count act on the next tick.
        set_config(8'd3, 8'd2, 8'd2, 8'd3);
        send_ticks(75);
        drain();
        send_ticks(75);
        drain();

        // Random small settings.
        for (int k = 0; k < 3; k++) begin
            set_config(8'($urandom_range(3, 1)), 8'($urandom_range(3, 1)),
                       8'($urandom_range(2, 1)), 8'($urandom_range(6, 0)));
            send_ticks(100);
            drain();
        end

        repeat (10) @(posedge clk);
        sb.flag_leftovers();
        if (sb.fails == 0)
            $display("led_animation_sequencer regression: pass");
        else
            $display("led_animation_sequencer regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/las_pkg.sv
src/las_cfg.sv
src/las_step.sv
src/led_animation_sequencer.sv
sim/led_animation_sequencer_test.sv
